// ----- hdl/rom_with_image_stream_port_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ROM with image stream port
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROM_WITH_IMAGE_STREAM_PORT_ASSERT_SVH
`define ROM_WITH_IMAGE_STREAM_PORT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define RWISP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rwisp check failed");
// Next-cycle implication, held off during reset.
`define RWISP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwisp check failed");
`else
`define RWISP_ASSERT_NOW(label, clk, rst, ante, cons)
`define RWISP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/rwisp_pkg.sv -----
// ----------------------------------------------------------------------------
// rwisp_pkg
// Sizes, codes and stage types of the ROM with image stream port.
// ----------------------------------------------------------------------------
package rwisp_pkg;

   // Store sizes. ROM_BYTES is a power of two, so the bus address folds by mask.
   localparam int ROM_BYTES   = 4096;
   localparam int IMAGE_COUNT = 4;
   localparam int IMAGE_BYTES = 672;
   localparam int IMG_DEPTH   = IMAGE_COUNT * IMAGE_BYTES;

   localparam int ADDR_W  = 15;
   localparam int DATA_W  = 8;
   localparam int FRAME_W = 16;
   localparam int MODE_W  = 2;

   localparam int ROM_AW = $clog2(ROM_BYTES);
   localparam int IMG_AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
   localparam int POS_W  = (IMAGE_BYTES > 1) ? $clog2(IMAGE_BYTES) : 1;
   localparam int NUM_W  = (IMAGE_COUNT > 1) ? $clog2(IMAGE_COUNT) : 1;

   localparam logic [POS_W-1:0]  POS_LAST = POS_W'(IMAGE_BYTES - 1);
   localparam logic [NUM_W-1:0]  NUM_LAST = NUM_W'(IMAGE_COUNT - 1);
   localparam logic [IMG_AW-1:0] IMG_STEP = IMG_AW'(IMAGE_BYTES);

   // Image load index folding: quotient by reciprocal, then one correction.
   localparam int Q_W       = $clog2((1 << ADDR_W) / IMG_DEPTH + 1) + 1;
   localparam int DIV_SHIFT = ADDR_W + IMG_AW + 1;
   localparam int RECIP_W   = ADDR_W + 3;
   localparam int PROD_W    = ADDR_W + RECIP_W;
   localparam longint unsigned RECIP_VAL = (64'd1 << DIV_SHIFT) / IMG_DEPTH;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic [ADDR_W:0] IMG_DEPTH_X = (ADDR_W + 1)'(IMG_DEPTH);

   // Register reset values.
   localparam logic [ADDR_W-1:0]  STREAM_ADDR_RST = 15'h0F00;
   localparam logic [FRAME_W-1:0] FRAMES_RST      = 16'd500;

   localparam int CSR_AW = 1;
   localparam int CSR_DW = 16;
   localparam logic [CSR_AW-1:0] CSR_STREAM_ADDRESS = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_FRAMES_PER_IMAGE = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_BUS_READ  = 2'd0,
      MODE_LOAD_PROG = 2'd1,
      MODE_LOAD_IMG  = 2'd2
   } mode_type;

   // Where a transaction's result byte comes from.
   typedef enum logic [1:0] {
      SRC_HOLD = 2'd0,
      SRC_PROG = 2'd1,
      SRC_IMG  = 2'd2
   } src_type;

   typedef struct packed {
      src_type             src;
      logic                wr_prog;
      logic                wr_img;
      logic [ROM_AW-1:0]   prog_addr;
      logic [IMG_AW-1:0]   img_idx;
      logic [ADDR_W-1:0]   addr;
      logic [Q_W-1:0]      quot;
      logic [DATA_W-1:0]   data;
   } stage1_type;

endpackage

// ----- hdl/rom_with_image_stream_port.sv -----
// ----------------------------------------------------------------------------
// rom_with_image_stream_port
// Byte ROM on a streamed bus with one address that plays out image bytes.
// ----------------------------------------------------------------------------
// Each request transaction is one bus access or one store load and yields
// exactly one response transaction. The block takes one transaction per clock
// while the response channel does not stall, passing each through decode
// (registered at acceptance), memory read and output register; the rate is set by
// the single port of each store, which serves one read or one write per cycle.
// A read of the stream address returns
// the current image byte. The first read elsewhere after a stream read does not
// drive the bus: it advances the image position and returns the held bus byte
// with the driven flag low; the first such advance after reset is skipped.
// After a full image the frame counter counts up, and once it exceeds
// frames_per_image the block moves to the next image, wrapping. Other reads
// return the program store at the address modulo ROM_BYTES. Load transactions
// fill the program store (index modulo ROM_BYTES) or the image store (index
// modulo the image store depth); image entry k of image n sits at
// n * IMAGE_BYTES + k. Both stores come up unwritten and there is no clearing
// pass: read only entries that were loaded. Write the CSRs only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module rom_with_image_stream_port (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [14:0] address, [22:15] load_data, [23] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_out
   output logic        rsp_tuser,   // [0] driven
   // CSR write port
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

`include "rom_with_image_stream_port_assert.svh"

   // CSRs
   logic [rwisp_pkg::ADDR_W-1:0]  stream_addr_ff;
   logic [rwisp_pkg::FRAME_W-1:0] frames_ff;

   // Image play-out state
   logic [rwisp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [rwisp_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [rwisp_pkg::IMG_AW-1:0]  base_ff, base_in;
   logic [rwisp_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [rwisp_pkg::ADDR_W-1:0]  prev_addr_ff, prev_addr_in;
   logic                          pending_ff, pending_in;
   logic [rwisp_pkg::DATA_W-1:0]  bus_ff;

   // Pipeline
   rwisp_pkg::stage1_type         s1_ff, s1_in;
   logic                          s1_valid_ff;
   rwisp_pkg::src_type            s2_src_ff;
   logic                          s2_valid_ff;
   logic [rwisp_pkg::DATA_W-1:0]  prog_q_ff, img_q_ff;
   logic                          rsp_valid_ff;
   logic [rwisp_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                          rsp_driven_ff;

   // Stores
   logic [rwisp_pkg::DATA_W-1:0]  prog_mem [rwisp_pkg::ROM_BYTES];
   logic [rwisp_pkg::DATA_W-1:0]  img_mem  [rwisp_pkg::IMG_DEPTH];

   // Decode
   logic                          req_acc;
   rwisp_pkg::mode_type           req_mode;
   logic [rwisp_pkg::ADDR_W-1:0]  req_addr;
   logic [rwisp_pkg::DATA_W-1:0]  req_data;
   logic                          is_read, hit_stream, do_advance;
   logic [rwisp_pkg::FRAME_W-1:0] frame_inc;
   logic [rwisp_pkg::PROD_W-1:0]  recip_prod;
   logic [rwisp_pkg::ADDR_W:0]    rem_wide, rem_fix;
   logic [rwisp_pkg::IMG_AW-1:0]  img_addr;
   logic                          out_free, s2_free, s1_free, s1_go, s2_go;

   // -------------------------------------------------------------------------
   // Flow control: each stage advances when the one ahead is empty or moving.
   // -------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_go      = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_go      = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_acc    = req_tvalid && req_tready;

   assign req_mode = rwisp_pkg::mode_type'(req_tuser);
   assign req_addr = req_tdata[14:0];
   assign req_data = req_tdata[22:15];

   // -------------------------------------------------------------------------
   // CSR writes
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_addr_ff <= rwisp_pkg::STREAM_ADDR_RST;
         frames_ff      <= rwisp_pkg::FRAMES_RST;
      end else if (csr_we) begin
         case (csr_index)
            rwisp_pkg::CSR_STREAM_ADDRESS: stream_addr_ff <= csr_wdata[14:0];
            rwisp_pkg::CSR_FRAMES_PER_IMAGE: frames_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stage 0: classify the access, step the play-out state, form addresses.
   // -------------------------------------------------------------------------
   always_comb begin
      is_read    = (req_mode == rwisp_pkg::MODE_BUS_READ);
      hit_stream = (req_addr == stream_addr_ff);
      do_advance = is_read && !hit_stream && (prev_addr_ff == stream_addr_ff);

      // Reciprocal estimate of the image load index quotient (low by at most 1).
      recip_prod = rwisp_pkg::PROD_W'(req_addr) * rwisp_pkg::PROD_W'(rwisp_pkg::RECIP);

      s1_in.src = rwisp_pkg::SRC_HOLD;
      if (is_read && hit_stream) begin
         s1_in.src = rwisp_pkg::SRC_IMG;
      end else if (is_read && !do_advance) begin
         s1_in.src = rwisp_pkg::SRC_PROG;
      end
      s1_in.wr_prog   = (req_mode == rwisp_pkg::MODE_LOAD_PROG);
      s1_in.wr_img    = (req_mode == rwisp_pkg::MODE_LOAD_IMG);
      s1_in.prog_addr = req_addr[rwisp_pkg::ROM_AW-1:0];
      s1_in.img_idx   = base_ff + rwisp_pkg::IMG_AW'(pos_ff);
      s1_in.addr      = req_addr;
      s1_in.quot      = recip_prod[rwisp_pkg::DIV_SHIFT +: rwisp_pkg::Q_W];
      s1_in.data      = req_data;

      // Advance: skip the very first one, else step and roll over frames.
      pos_in    = pos_ff;
      num_in    = num_ff;
      base_in   = base_ff;
      frame_in  = frame_ff;
      pending_in = pending_ff;
      frame_inc = frame_ff + 1'b1;
      if (req_acc && do_advance) begin
         if (pending_ff) begin
            pending_in = 1'b0;
         end else if (pos_ff == rwisp_pkg::POS_LAST) begin
            pos_in = '0;
            if (frame_inc > frames_ff) begin
               frame_in = '0;
               if (num_ff == rwisp_pkg::NUM_LAST) begin
                  num_in  = '0;
                  base_in = '0;
               end else begin
                  num_in  = num_ff + 1'b1;
                  base_in = base_ff + rwisp_pkg::IMG_STEP;
               end
            end else begin
               frame_in = frame_inc;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      prev_addr_in = (req_acc && is_read) ? req_addr : prev_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         num_ff       <= '0;
         base_ff      <= '0;
         frame_ff     <= '0;
         prev_addr_ff <= '0;
         pending_ff   <= 1'b1;
      end else begin
         pos_ff       <= pos_in;
         num_ff       <= num_in;
         base_ff      <= base_in;
         frame_ff     <= frame_in;
         prev_addr_ff <= prev_addr_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: finish the image load index, then read or write the stores.
   // -------------------------------------------------------------------------
   always_comb begin
      rem_wide = {1'b0, s1_ff.addr}
               - (rwisp_pkg::ADDR_W + 1)'(s1_ff.quot * rwisp_pkg::IMG_DEPTH);
      rem_fix  = (rem_wide >= rwisp_pkg::IMG_DEPTH_X) ? rem_wide - rwisp_pkg::IMG_DEPTH_X
                                                      : rem_wide;
      img_addr = s1_ff.wr_img ? rem_fix[rwisp_pkg::IMG_AW-1:0] : s1_ff.img_idx;
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         if (s1_ff.wr_prog) begin
            prog_mem[s1_ff.prog_addr] <= s1_ff.data;
         end
         prog_q_ff <= prog_mem[s1_ff.prog_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         if (s1_ff.wr_img) begin
            img_mem[img_addr] <= s1_ff.data;
         end
         img_q_ff <= img_mem[img_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_go;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_src_ff <= s1_ff.src;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: pick the byte, update the held bus value, present the response.
   // -------------------------------------------------------------------------
   always_comb begin
      case (s2_src_ff)
         rwisp_pkg::SRC_PROG: rsp_data_in = prog_q_ff;
         rwisp_pkg::SRC_IMG:  rsp_data_in = img_q_ff;
         default:             rsp_data_in = bus_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bus_ff       <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= s2_go;
         end
         if (s2_go) begin
            bus_ff <= rsp_data_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_driven_ff <= (s2_src_ff != rwisp_pkg::SRC_HOLD);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_driven_ff;

   // -------------------------------------------------------------------------
   // Checks
   // -------------------------------------------------------------------------
   `RWISP_ASSERT_NOW(a_base_tracks_image, clock, reset, 1'b1,
      base_ff == rwisp_pkg::IMG_AW'(num_ff * rwisp_pkg::IMAGE_BYTES))
   `RWISP_ASSERT_NOW(a_pos_in_image, clock, reset, 1'b1,
      rwisp_pkg::IMG_AW'(pos_ff) < rwisp_pkg::IMG_STEP)
   `RWISP_ASSERT_NEXT(a_stream_read_uses_image, clock, reset,
      req_acc && is_read && hit_stream, s1_valid_ff && s1_ff.src == rwisp_pkg::SRC_IMG)
   `RWISP_ASSERT_NOW(a_skip_only_on_advance, clock, reset,
      !pending_ff && $past(pending_ff) && !$past(reset), $past(req_acc && do_advance))
   `RWISP_ASSERT_NEXT(a_read_reaches_stage2, clock, reset, s1_go, s2_valid_ff)

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ROM with image stream port.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of both stores, the image walk state
// and the two CSRs. It predicts the bus byte and driven flag for every request
// transaction as it is accepted, and checks each response transaction in
// order. Plain tasks drive the request channel and the CSR port. A separate
// process drives rsp_tready, with random stalls and one long hold-off.
// The stimulus is built from the predicted state, so no store entry is ever
// read before it has been loaded:
//  - a short directed part covers field extremes, every mode, address and
//    load index folding, the skipped first advance and the held bus byte;
//  - random phases mix stream and advance pairs with loads, program reads
//    and unused-mode noise, under four idling patterns and several CSR values.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 600000;
   // Mode code the block ignores.
   localparam logic [rwisp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [rwisp_pkg::DATA_W-1:0] data_out;
      logic                         driven;
   } bus_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: image stream ROM predictor plus in-order response check.
   // -------------------------------------------------------------------------
   class rom_scoreboard;
      logic [rwisp_pkg::DATA_W-1:0]  prog_mem [rwisp_pkg::ROM_BYTES];
      bit                            prog_set [rwisp_pkg::ROM_BYTES];
      logic [rwisp_pkg::DATA_W-1:0]  img_mem  [rwisp_pkg::IMG_DEPTH];
      bit                            img_set  [rwisp_pkg::IMG_DEPTH];
      int                            prog_list [$];     // program indexes loaded so far

      int                            pos;
      int                            num;
      logic [rwisp_pkg::FRAME_W-1:0] frames;
      logic [rwisp_pkg::ADDR_W-1:0]  prev_addr;
      bit                            skip_first;
      logic [rwisp_pkg::DATA_W-1:0]  bus;
      logic [rwisp_pkg::ADDR_W-1:0]  stream_addr;
      logic [rwisp_pkg::FRAME_W-1:0] frame_limit;

      bus_result_type                expected_bus [$];

      int accepted, checked, drove, advances, frames_done, switches, mismatches;

      function new();
         pos = 0;
         num = 0;
         frames = '0;
         prev_addr = '0;
         skip_first = 1'b1;
         bus = '0;
         stream_addr = rwisp_pkg::STREAM_ADDR_RST;
         frame_limit = rwisp_pkg::FRAMES_RST;
      endfunction

      function void set_reg(logic [rwisp_pkg::CSR_AW-1:0] index,
                            logic [rwisp_pkg::CSR_DW-1:0] value);
         if (index == rwisp_pkg::CSR_STREAM_ADDRESS) stream_addr = value[rwisp_pkg::ADDR_W-1:0];
         else frame_limit = value;
      endfunction

      function int image_index();
         return num * rwisp_pkg::IMAGE_BYTES + pos;
      endfunction

      function bit image_ready();
         return img_set[image_index()];
      endfunction

      // A non-stream bus read right now would advance the image instead.
      function bit advance_next();
         return prev_addr == stream_addr;
      endfunction

      function int pending();
         return expected_bus.size();
      endfunction

      function void step_image();
         advances++;
         if (skip_first) skip_first = 1'b0;
         else pos++;
         if (pos >= rwisp_pkg::IMAGE_BYTES) begin
            frames = frames + 1'b1;
            frames_done++;
            if (frames > frame_limit) begin
               frames = '0;
               num = (num + 1 >= rwisp_pkg::IMAGE_COUNT) ? 0 : num + 1;
               switches++;
            end
            pos = 0;
         end
      endfunction

      function void note_access(logic [rwisp_pkg::MODE_W-1:0] mode,
                                logic [rwisp_pkg::ADDR_W-1:0] addr,
                                logic [rwisp_pkg::DATA_W-1:0] data);
         bus_result_type res;
         int idx;
         res.driven = 1'b0;
         case (mode)
            rwisp_pkg::MODE_BUS_READ: begin
               if (addr == stream_addr) begin
                  bus = img_mem[image_index()];
                  res.driven = 1'b1;
               end else if (prev_addr == stream_addr) begin
                  step_image();
               end else begin
                  bus = prog_mem[int'(addr) % rwisp_pkg::ROM_BYTES];
                  res.driven = 1'b1;
               end
               prev_addr = addr;
            end
            rwisp_pkg::MODE_LOAD_PROG: begin
               idx = int'(addr) % rwisp_pkg::ROM_BYTES;
               prog_mem[idx] = data;
               if (!prog_set[idx]) begin
                  prog_set[idx] = 1'b1;
                  prog_list.push_back(idx);
               end
            end
            rwisp_pkg::MODE_LOAD_IMG: begin
               idx = int'(addr) % rwisp_pkg::IMG_DEPTH;
               img_mem[idx] = data;
               img_set[idx] = 1'b1;
            end
            default: ;
         endcase
         res.data_out = bus;
         expected_bus.push_back(res);
         accepted++;
      endfunction

      function void check_bus_result(logic [rwisp_pkg::DATA_W-1:0] data_out, logic driven);
         bus_result_type want;
         if (expected_bus.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: response data_out=%02h driven=%0b with nothing expected",
                        data_out, driven);
            return;
         end
         want = expected_bus.pop_front();
         checked++;
         if (driven) drove++;
         if (want.data_out !== data_out || want.driven !== driven) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch on response %0d: expected data_out=%02h driven=%0b,",
                         " got data_out=%02h driven=%0b"},
                        checked, want.data_out, want.driven, data_out, driven);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [14:0] address, [22:15] load_data, [23] zero
   logic [1:0]  req_tuser = '0;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] data_out
   logic        rsp_tuser;        // [0] driven
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   rom_scoreboard board;
   int send_idle_pct = 0;    // chance per cycle that the sender sits idle
   int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int hold_cycles = 0;      // long receiver hold-off, counted down below
   int cycle_count = 0;

   rom_with_image_stream_port dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Receiver: drop rsp_tready during a hold-off, otherwise stall at random.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every response transaction at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_bus_result(rsp_tdata, rsp_tuser);
   end

   // Watchdog: end the run if it takes far longer than any correct run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, board.pending());
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request driver. Change inputs at the falling edge, note the transaction
   // in the scoreboard at the rising edge that accepts it, so the next item
   // is always generated from up-to-date predicted state.
   // -------------------------------------------------------------------------
   task automatic send_access(input logic [rwisp_pkg::MODE_W-1:0] mode,
                              input logic [rwisp_pkg::ADDR_W-1:0] addr,
                              input logic [rwisp_pkg::DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_access(mode, addr, data);
   endtask

   // Drop valid and wait until every response is back; the block is idle then.
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rwisp_pkg::CSR_AW-1:0] index,
                            input logic [rwisp_pkg::CSR_DW-1:0] value);
      wait_quiet();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      board.set_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Load the image entry the stream reads next, through an index that may be folded.
   task automatic load_current_image_byte();
      int idx;
      int k;
      idx = board.image_index();
      k = $urandom_range((32767 - idx) / rwisp_pkg::IMG_DEPTH, 0);
      send_access(rwisp_pkg::MODE_LOAD_IMG,
                  rwisp_pkg::ADDR_W'(idx + k * rwisp_pkg::IMG_DEPTH),
                  rwisp_pkg::DATA_W'($urandom));
   endtask

   // Read the stream address; load the entry first if it was never written.
   task automatic stream_read();
      if (!board.image_ready()) load_current_image_byte();
      send_access(rwisp_pkg::MODE_BUS_READ, board.stream_addr, rwisp_pkg::DATA_W'($urandom));
   endtask

   // Bus read away from the stream address: an advance right after a stream
   // read, otherwise a program read of a loaded entry at any alias (or just a program load while none is loaded).
   task automatic other_read();
      logic [rwisp_pkg::ADDR_W-1:0] addr;
      int idx;
      if (board.advance_next()) begin
         addr = rwisp_pkg::ADDR_W'($urandom);
         if (addr == board.stream_addr) addr = addr ^ 15'h0001;
      end else if (board.prog_list.size() == 0) begin
         send_access(rwisp_pkg::MODE_LOAD_PROG, rwisp_pkg::ADDR_W'($urandom),
                     rwisp_pkg::DATA_W'($urandom));
         return;
      end else begin
         idx = board.prog_list[$urandom_range(board.prog_list.size() - 1, 0)];
         addr = rwisp_pkg::ADDR_W'(idx + rwisp_pkg::ROM_BYTES * $urandom_range(7, 0));
         if (addr == board.stream_addr) addr = addr ^ 15'h1000;
      end
      send_access(rwisp_pkg::MODE_BUS_READ, addr, rwisp_pkg::DATA_W'($urandom));
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 30)      stream_read();
      else if (pick < 55) other_read();
      else if (pick < 68) send_access(rwisp_pkg::MODE_LOAD_PROG, rwisp_pkg::ADDR_W'($urandom),
                                      rwisp_pkg::DATA_W'($urandom));
      else if (pick < 80) send_access(rwisp_pkg::MODE_LOAD_IMG, rwisp_pkg::ADDR_W'($urandom),
                                      rwisp_pkg::DATA_W'($urandom));
      else if (pick < 86) send_access(MODE_UNUSED, rwisp_pkg::ADDR_W'($urandom),
                                      rwisp_pkg::DATA_W'($urandom));
      else                load_current_image_byte();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      board = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset CSR values (stream address 0xF00).
      send_access(rwisp_pkg::MODE_LOAD_PROG, 15'h0000, 8'h00);
      send_access(rwisp_pkg::MODE_LOAD_PROG, 15'h7FFF, 8'hFF);    // folds to the top entry
      send_access(rwisp_pkg::MODE_LOAD_PROG, 15'h1000, 8'h5A);    // folds onto entry zero
      send_access(rwisp_pkg::MODE_LOAD_IMG,  15'h0000, 8'hC3);
      send_access(rwisp_pkg::MODE_LOAD_IMG,  15'h7FFF, 8'h81);    // folds past the depth
      send_access(rwisp_pkg::MODE_LOAD_IMG,
                  rwisp_pkg::ADDR_W'(rwisp_pkg::IMG_DEPTH - 1), 8'h7E);
      send_access(MODE_UNUSED,               15'h7FFF, 8'hFF);    // ignored mode
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h0000, 8'h00);
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h7FFF, 8'hFF);
      send_access(rwisp_pkg::MODE_LOAD_PROG, 15'h0001, 8'h33);    // load holds the bus byte
      send_access(rwisp_pkg::MODE_BUS_READ,  board.stream_addr, 8'h00);
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h0000, 8'h00);    // first advance is skipped
      send_access(rwisp_pkg::MODE_BUS_READ,  board.stream_addr, 8'hFF);
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h7FFF, 8'h00);    // advance to position one
      send_access(rwisp_pkg::MODE_LOAD_IMG,  15'h0001, 8'h99);
      send_access(rwisp_pkg::MODE_BUS_READ,  board.stream_addr, 8'h00);
      send_access(rwisp_pkg::MODE_BUS_READ,  board.stream_addr, 8'h00);  // back to back
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h0001, 8'h00);    // advance again
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h0001, 8'h00);    // plain program read
      send_access(rwisp_pkg::MODE_BUS_READ,  15'h1001, 8'h00);    // aliased program read

      // Random phases, one idling pattern and CSR setting each.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_idle(0, 0);
               write_csr(rwisp_pkg::CSR_STREAM_ADDRESS,
                         rwisp_pkg::CSR_DW'(rwisp_pkg::STREAM_ADDR_RST));
               write_csr(rwisp_pkg::CSR_FRAMES_PER_IMAGE, 16'd0);
            end
            1: begin
               set_idle(47, 0);
               write_csr(rwisp_pkg::CSR_STREAM_ADDRESS,
                         rwisp_pkg::CSR_DW'($urandom_range(32767, 0)));
               write_csr(rwisp_pkg::CSR_FRAMES_PER_IMAGE,
                         rwisp_pkg::CSR_DW'($urandom_range(3, 0)));
            end
            2: begin
               set_idle(0, 47);
               write_csr(rwisp_pkg::CSR_STREAM_ADDRESS, 16'h7FFF);
               write_csr(rwisp_pkg::CSR_FRAMES_PER_IMAGE, 16'hFFFF);
            end
            default: begin
               set_idle(27, 27);
               // Below ROM_BYTES, so the stream address shadows a program entry.
               write_csr(rwisp_pkg::CSR_STREAM_ADDRESS,
                         rwisp_pkg::CSR_DW'($urandom_range(rwisp_pkg::ROM_BYTES - 1, 0)));
               write_csr(rwisp_pkg::CSR_FRAMES_PER_IMAGE, 16'd1);
            end
         endcase
         for (int n = 0; n < 165; n++) begin
            // Hold the receiver off while requests keep coming, to back the
            // block up until it stalls its input.
            if (phase == 0 && n == 20) hold_cycles = 400;
            random_item();
         end
      end

      // Drain, then keep watching the response channel for any stray
      // response transaction.
      wait_quiet();
      repeat (8) @(posedge clock);

      $display("Covered %0d request transactions: %0d image advances, %0d frames",
               board.accepted, board.advances, board.frames_done);
      $display("Checked %0d response transactions (%0d driven), %0d mismatches",
               board.checked, board.drove, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
